// ===== rtl/core/qme3_pkg.sv =====
// ----------------------------------------------------------------------------
// qme3_pkg
// Shared constants, register indexes and helpers for the 3D Morton quantizer.
// ----------------------------------------------------------------------------
package qme3_pkg;

  localparam int AXIS_BITS_DEF   = 21;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int SIZE_W          = 31;
  localparam int CODE_W          = 63;
  localparam int CFG_IDX_W       = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CUBE_SIZE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 3'd4;

  localparam logic [SIZE_W-1:0] CUBE_SIZE_RST = 31'd65536;
  localparam logic [SIZE_W-1:0] CELL_SIZE_RST = 31'd1;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/core/qme3_div_step.sv =====
// ----------------------------------------------------------------------------
// qme3_div_step
// One registered restoring-division step: resolves quotient bit SHIFT.
// ----------------------------------------------------------------------------
module qme3_div_step
  import qme3_pkg::*;
#(
  parameter int AXIS_BITS = AXIS_BITS_DEF,
  parameter int REM_W     = 34,
  parameter int D_W       = SIZE_W + 1,
  parameter int SHIFT     = 0
) (
  input  logic                 clk,
  input  logic [REM_W-1:0]     rem_in,
  input  logic [AXIS_BITS-1:0] q_in,
  input  logic                 ok_in,
  input  logic [D_W-1:0]       divisor,
  output logic [REM_W-1:0]     rem_out,
  output logic [AXIS_BITS-1:0] q_out,
  output logic                 ok_out
);

  localparam int CW = imax(REM_W, D_W + SHIFT) + 1;

  logic [CW-1:0]        diff;
  logic                 take;
  logic [REM_W-1:0]     rem_next;
  logic [AXIS_BITS-1:0] q_next;

  // both operands are below 2^(CW-1), so the top bit is the borrow
  assign diff     = CW'(rem_in) - (CW'(divisor) << SHIFT);
  assign take     = ~diff[CW-1];
  assign rem_next = take ? diff[REM_W-1:0] : rem_in;

  always_comb begin
    q_next        = q_in;
    q_next[SHIFT] = take;
  end

  always_ff @(posedge clk) begin
    rem_out <= rem_next;
    q_out   <= q_next;
    ok_out  <= ok_in;
  end

endmodule

// ===== rtl/core/qme3_axis.sv =====
// ----------------------------------------------------------------------------
// qme3_axis
// One axis: doubled offset from the cube minimum, range check, then a
// pipelined restoring divider giving the floored cell index.
// ----------------------------------------------------------------------------
module qme3_axis
  import qme3_pkg::*;
#(
  parameter int AXIS_BITS   = AXIS_BITS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic signed [COORD_WIDTH-1:0] pos,
  input  logic signed [COORD_WIDTH-1:0] center,
  input  logic        [SIZE_W-1:0]      cube_size,
  input  logic        [SIZE_W:0]        divisor,
  output logic        [AXIS_BITS-1:0]   idx,
  output logic                          ok
);

  localparam int OFF_W = imax(COORD_WIDTH + 2, SIZE_W + 1) + 1;
  localparam int REM_W = OFF_W - 1;
  localparam int D_W   = SIZE_W + 1;
  localparam int CW    = imax(REM_W, D_W + AXIS_BITS) + 1;

  logic signed [OFF_W-1:0] pos_e;
  logic signed [OFF_W-1:0] ctr_e;
  logic signed [OFF_W-1:0] twice_next;
  logic signed [OFF_W-1:0] twice;

  logic [CW-1:0]        lim_diff;
  logic [REM_W-1:0]     rem_s [0:AXIS_BITS];
  logic [AXIS_BITS-1:0] q_s   [0:AXIS_BITS];
  logic                 ok_s  [0:AXIS_BITS];

  // stage 1: 2*(pos - center) + cube_size, exact
  assign pos_e      = OFF_W'(pos);
  assign ctr_e      = OFF_W'(center);
  assign twice_next = ((pos_e - ctr_e) <<< 1) + signed'(OFF_W'(cube_size));

  always_ff @(posedge clk) begin
    twice <= twice_next;
  end

  // stage 2: quotient fits only if twice < divisor << AXIS_BITS
  assign lim_diff = CW'(twice[REM_W-1:0]) - (CW'(divisor) << AXIS_BITS);

  always_ff @(posedge clk) begin
    rem_s[0] <= twice[REM_W-1:0];
    ok_s[0]  <= ~twice[OFF_W-1] & lim_diff[CW-1];
  end

  assign q_s[0] = '0;

  // one quotient bit per stage, MSB first
  for (genvar i = 0; i < AXIS_BITS; i++) begin : g_step
    qme3_div_step #(
      .AXIS_BITS (AXIS_BITS),
      .REM_W     (REM_W),
      .D_W       (D_W),
      .SHIFT     (AXIS_BITS - 1 - i)
    ) u_step (
      .clk     (clk),
      .rem_in  (rem_s[i]),
      .q_in    (q_s[i]),
      .ok_in   (ok_s[i]),
      .divisor (divisor),
      .rem_out (rem_s[i+1]),
      .q_out   (q_s[i+1]),
      .ok_out  (ok_s[i+1])
    );
  end

  assign idx = q_s[AXIS_BITS];
  assign ok  = ok_s[AXIS_BITS];

endmodule

// ===== rtl/core/qme3_interleave.sv =====
// ----------------------------------------------------------------------------
// qme3_interleave
// Output register: bit-interleaves the three indices into the Morton code.
// ----------------------------------------------------------------------------
module qme3_interleave
  import qme3_pkg::*;
#(
  parameter int AXIS_BITS = AXIS_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vld,
  input  logic                 ok_x,
  input  logic                 ok_y,
  input  logic                 ok_z,
  input  logic [AXIS_BITS-1:0] ix,
  input  logic [AXIS_BITS-1:0] iy,
  input  logic [AXIS_BITS-1:0] iz,
  output logic                 done,
  output logic [CODE_W-1:0]    morton_code,
  output logic                 in_space
);

  logic              ok_all;
  logic [CODE_W-1:0] code_next;

  assign ok_all = ok_x & ok_y & ok_z;

  always_comb begin
    code_next = '0;
    if (ok_all) begin
      for (int b = 0; b < AXIS_BITS; b++) begin
        code_next[3*b]     = ix[b];
        code_next[3*b + 1] = iy[b];
        code_next[3*b + 2] = iz[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld;
    end
  end

  always_ff @(posedge clk) begin
    morton_code <= code_next;
    in_space    <= ok_all;
  end

endmodule

// ===== rtl/core/quantize_morton_encode_3d_core.sv =====
// ----------------------------------------------------------------------------
// quantize_morton_encode_3d_core
// Quantizes a Q16.16 point to per-axis cell indices and Morton-encodes them.
// ----------------------------------------------------------------------------
// Usage:
//   A request (pos_x/y/z) is taken on any clock edge with start high; busy
//   is always low, so a new point may enter every cycle.
//   Each result appears on morton_code/in_space for one cycle with done high,
//   in request order.
//   Throughput is one point per cycle: per axis, an offset stage, a range
//   check stage and one restoring-divider stage per index bit, then the
//   interleave output register.
//   The receiver cannot stall, so the pipeline never holds.
//   Configuration (cfg_we/cfg_index/cfg_data) writes one register per edge
//   and is applied directly to all stages; write it only while no request
//   is in flight.
//   Synchronous reset clears the in-flight valid bits and restores the
//   registers: centers 0, cube_size 1.0, cell_size one LSB.
// ----------------------------------------------------------------------------
module quantize_morton_encode_3d_core
  import qme3_pkg::*;
#(
  parameter int AXIS_BITS   = AXIS_BITS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int CFG_W       = imax(COORD_WIDTH, SIZE_W)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  output logic                          done,
  output logic        [CODE_W-1:0]      morton_code,
  output logic                          in_space,
  input  logic                          cfg_we,
  input  logic        [CFG_IDX_W-1:0]   cfg_index,
  input  logic        [CFG_W-1:0]       cfg_data
);

  localparam int LAT = AXIS_BITS + 2;

  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic signed [COORD_WIDTH-1:0] center_z;
  logic        [SIZE_W-1:0]      cube_size;
  logic        [SIZE_W-1:0]      cell_size;
  logic        [SIZE_W:0]        divisor;

  logic [LAT-1:0]       vld;
  logic [AXIS_BITS-1:0] ix, iy, iz;
  logic                 ok_x, ok_y, ok_z;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x  <= '0;
      center_y  <= '0;
      center_z  <= '0;
      cube_size <= CUBE_SIZE_RST;
      cell_size <= CELL_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X:  center_x  <= cfg_data[COORD_WIDTH-1:0];
        REG_CENTER_Y:  center_y  <= cfg_data[COORD_WIDTH-1:0];
        REG_CENTER_Z:  center_z  <= cfg_data[COORD_WIDTH-1:0];
        REG_CUBE_SIZE: cube_size <= cfg_data[SIZE_W-1:0];
        REG_CELL_SIZE: cell_size <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // 2*cell_size, with zero treated as one LSB
  assign divisor = {((cell_size == '0) ? SIZE_W'(1) : cell_size), 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  qme3_axis #(.AXIS_BITS(AXIS_BITS), .COORD_WIDTH(COORD_WIDTH)) u_axis_x (
    .clk       (clk),
    .pos       (pos_x),
    .center    (center_x),
    .cube_size (cube_size),
    .divisor   (divisor),
    .idx       (ix),
    .ok        (ok_x)
  );

  qme3_axis #(.AXIS_BITS(AXIS_BITS), .COORD_WIDTH(COORD_WIDTH)) u_axis_y (
    .clk       (clk),
    .pos       (pos_y),
    .center    (center_y),
    .cube_size (cube_size),
    .divisor   (divisor),
    .idx       (iy),
    .ok        (ok_y)
  );

  qme3_axis #(.AXIS_BITS(AXIS_BITS), .COORD_WIDTH(COORD_WIDTH)) u_axis_z (
    .clk       (clk),
    .pos       (pos_z),
    .center    (center_z),
    .cube_size (cube_size),
    .divisor   (divisor),
    .idx       (iz),
    .ok        (ok_z)
  );

  qme3_interleave #(.AXIS_BITS(AXIS_BITS)) u_interleave (
    .clk         (clk),
    .rst         (rst),
    .vld         (vld[LAT-1]),
    .ok_x        (ok_x),
    .ok_y        (ok_y),
    .ok_z        (ok_z),
    .ix          (ix),
    .iy          (iy),
    .iz          (iz),
    .done        (done),
    .morton_code (morton_code),
    .in_space    (in_space)
  );

endmodule
